@@ rtl/core/sdet_pkg.sv @@
// Shared constants, word types and control types of the sorted delta event table.
package sdet_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int TIME_W      = 20;
  localparam int PAY_W       = 16;
  localparam int STAT_W      = 3;
  localparam int ECNT_W      = 5;

  localparam logic [TIME_W-1:0] TIME_MAX = TIME_W'(999999);

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_REPLACED  = 3'd1;
  localparam logic [STAT_W-1:0] ST_REMOVED   = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic              mode;
    logic [TIME_W-1:0] event_time;
    logic [PAY_W-1:0]  payload_handle;
  } in_data_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [TIME_W-1:0] prev_delta;
    logic [TIME_W-1:0] new_delta;
    logic [PAY_W-1:0]  released_payload;
    logic [ECNT_W-1:0] entry_count;
    logic              list_empty;
  } out_data_t;

  // Broadcast from the sequencer to every cell
  typedef struct packed {
    logic              cmp;
    logic              ins;
    logic              rep;
    logic              rem;
    logic [TIME_W-1:0] event_time;
    logic [PAY_W-1:0]  handle;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

endpackage

@@ rtl/core/sdet_cell.sv @@
// One slot of the sorted chain: holds a time and handle, compares and shifts.
module sdet_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sdet_pkg::cell_cmd_t       cmd,
  input  logic                      occ,
  input  logic                      left_lt,
  input  logic [sdet_pkg::TIME_W-1:0] left_time,
  input  logic [sdet_pkg::PAY_W-1:0]  left_pay,
  input  logic [sdet_pkg::TIME_W-1:0] right_time,
  input  logic [sdet_pkg::PAY_W-1:0]  right_pay,
  output logic [sdet_pkg::TIME_W-1:0] time_o,
  output logic [sdet_pkg::PAY_W-1:0]  pay_o,
  output logic                      lt_o,
  output logic                      eq_o
);
  import sdet_pkg::*;

  logic [TIME_W-1:0] time_r, time_nxt;
  logic [PAY_W-1:0]  pay_r, pay_nxt;
  logic              lt_r, lt_nxt;
  logic              eq_r, eq_nxt;

  // Compare against the broadcast time
  always_comb begin
    lt_nxt = lt_r;
    eq_nxt = eq_r;
    if (cmd.cmp) begin
      lt_nxt = occ && (time_r < cmd.event_time);
      eq_nxt = occ && (time_r == cmd.event_time);
    end
  end

  // Keep, load the new word, or take a neighbour's entry
  always_comb begin
    time_nxt = time_r;
    pay_nxt  = pay_r;
    if (cmd.ins && !lt_r) begin
      if (left_lt) begin
        time_nxt = cmd.event_time;
        pay_nxt  = cmd.handle;
      end else begin
        time_nxt = left_time;
        pay_nxt  = left_pay;
      end
    end else if (cmd.rep && eq_r) begin
      pay_nxt = cmd.handle;
    end else if (cmd.rem && !lt_r) begin
      time_nxt = right_time;
      pay_nxt  = right_pay;
    end
  end

  always_ff @(posedge clk) begin
    time_r <= time_nxt;
    pay_r  <= pay_nxt;
    if (!rst_n) begin
      lt_r <= 1'b0;
      eq_r <= 1'b0;
    end else begin
      lt_r <= lt_nxt;
      eq_r <= eq_nxt;
    end
  end

  assign time_o = time_r;
  assign pay_o  = pay_r;
  assign lt_o   = lt_r;
  assign eq_o   = eq_r;

endmodule

@@ rtl/core/sorted_delta_event_table.sv @@
// Top level: sequencer, cell chain, delta selection and result register.
//
// Holds up to TABLE_DEPTH (16) events sorted by time in a chain of cells.
// A word is taken in only while the sequencer is idle. In the next cycle
// every cell compares its time with the new one in parallel. Then, in the
// update step, the chain shifts by one place (insert makes room, remove
// closes the gap) while the deltas are formed from the neighbouring cells.
// The result is registered when the update step runs. One word is worked
// on at a time: no new word is taken before the last one is done. A
// finished result waits in the output register while the next word is
// taken in, and the update step waits only if that register is still full.
module sorted_delta_event_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sdet_pkg::in_data_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sdet_pkg::out_data_t out_data
);
  import sdet_pkg::*;

  localparam int D = TABLE_DEPTH;

  state_t              state_r, state_nxt;
  in_data_t            item_r, item_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_data_t           out_data_r, out_data_nxt;

  cell_cmd_t           cmd;
  logic [D-1:0]        occ, lt_v, eq_v, left_lt;
  logic [D-1:0]        pred_sel, at_sel, after_sel;
  logic [TIME_W-1:0]   cell_time [D];
  logic [PAY_W-1:0]    cell_pay  [D];

  logic                in_fire, upd_go, hit, full;
  logic                pred_v, at_v, after_v;
  logic [TIME_W-1:0]   pred_t, at_t, after_t, base_t;
  logic [PAY_W-1:0]    hit_pay;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign upd_go   = (state_r == S_UPD) && (!out_valid_r || out_ready);

  // Occupancy of each slot follows from the count
  always_comb begin
    for (int i = 0; i < D; i++) begin
      occ[i] = (CNT_W'(i) < cnt_r);
    end
  end

  assign hit  = |eq_v;
  assign full = (cnt_r == CNT_W'(D));

  // Locate predecessor, slot at position and slot after it
  always_comb begin
    for (int i = 0; i < D; i++) begin
      left_lt[i]  = (i == 0) ? 1'b1 : lt_v[(i == 0) ? 0 : i - 1];
      pred_sel[i] = lt_v[i] && ((i == D - 1) ? 1'b1 : !lt_v[(i == D - 1) ? i : i + 1]);
      at_sel[i]   = !lt_v[i] && left_lt[i] && occ[i];
    end
    for (int i = 0; i < D; i++) begin
      after_sel[i] = (i == 0) ? 1'b0 : (at_sel[(i == 0) ? 0 : i - 1] && occ[i]);
    end
  end

  // Pick neighbour times and the matching handle
  always_comb begin
    pred_t  = '0;
    at_t    = '0;
    after_t = '0;
    hit_pay = '0;
    for (int i = 0; i < D; i++) begin
      pred_t  = pred_t  | (cell_time[i] & {TIME_W{pred_sel[i]}});
      at_t    = at_t    | (cell_time[i] & {TIME_W{at_sel[i]}});
      after_t = after_t | (cell_time[i] & {TIME_W{after_sel[i]}});
      hit_pay = hit_pay | (cell_pay[i]  & {PAY_W{eq_v[i]}});
    end
  end

  assign pred_v  = |pred_sel;
  assign at_v    = |at_sel;
  assign after_v = |after_sel;
  assign base_t  = pred_v ? pred_t : '0;

  // Broadcast command to the chain
  always_comb begin
    cmd            = '0;
    cmd.event_time = item_r.event_time;
    cmd.handle     = item_r.payload_handle;
    cmd.cmp        = (state_r == S_CMP);
    if (upd_go) begin
      if (item_r.mode == MODE_INSERT) begin
        cmd.rep = hit;
        cmd.ins = !hit && !full;
      end else begin
        cmd.rem = hit;
      end
    end
  end

  // Sequencer, count and result
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          item_nxt = in_data;
          if (in_data.event_time > TIME_MAX) begin
            item_nxt.event_time = TIME_MAX;
          end
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (upd_go) begin
          out_data_nxt = '0;
          if (item_r.mode == MODE_INSERT) begin
            if (hit) begin
              out_data_nxt.status           = ST_REPLACED;
              out_data_nxt.released_payload = hit_pay;
              out_data_nxt.prev_delta       = item_r.event_time - base_t;
              out_data_nxt.new_delta        = after_v ? after_t - item_r.event_time : '0;
            end else if (full) begin
              out_data_nxt.status = ST_FULL;
            end else begin
              out_data_nxt.status     = ST_INSERTED;
              out_data_nxt.prev_delta = item_r.event_time - base_t;
              out_data_nxt.new_delta  = at_v ? at_t - item_r.event_time : '0;
              cnt_nxt                 = cnt_r + 1'b1;
            end
          end else begin
            if (hit) begin
              out_data_nxt.status           = ST_REMOVED;
              out_data_nxt.released_payload = hit_pay;
              out_data_nxt.prev_delta       = after_v ? after_t - base_t : '0;
              cnt_nxt                       = cnt_r - 1'b1;
            end else begin
              out_data_nxt.status = ST_NOT_FOUND;
            end
          end
          out_data_nxt.entry_count = ECNT_W'(cnt_nxt);
          out_data_nxt.list_empty  = (cnt_nxt == '0);
          out_valid_nxt            = 1'b1;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Chain of cells, each wired to both neighbours
  for (genvar g = 0; g < D; g++) begin : g_cell
    logic [TIME_W-1:0] lt_time, rt_time;
    logic [PAY_W-1:0]  lt_pay, rt_pay;
    if (g == 0) begin : g_first
      assign lt_time = '0;
      assign lt_pay  = '0;
    end else begin : g_mid_l
      assign lt_time = cell_time[g-1];
      assign lt_pay  = cell_pay[g-1];
    end
    if (g == D - 1) begin : g_last
      assign rt_time = '0;
      assign rt_pay  = '0;
    end else begin : g_mid_r
      assign rt_time = cell_time[g+1];
      assign rt_pay  = cell_pay[g+1];
    end
    sdet_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .occ        (occ[g]),
      .left_lt    (left_lt[g]),
      .left_time  (lt_time),
      .left_pay   (lt_pay),
      .right_time (rt_time),
      .right_pay  (rt_pay),
      .time_o     (cell_time[g]),
      .pay_o      (cell_pay[g]),
      .lt_o       (lt_v[g]),
      .eq_o       (eq_v[g])
    );
  end

  // Count never passes the table size
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(D))
    else $error("entry count above table depth");

  // Sorted distinct times give at most one matching slot
  a_eq_single: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> $onehot0(eq_v))
    else $error("more than one slot matches the time");

  // Matches and smaller times never overlap in a slot
  a_lt_eq_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> ((lt_v & eq_v) == '0))
    else $error("slot both below and equal to the time");

  // A fresh insert grows the count by one
  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("insert did not advance the count");

  // A result appears only from the update step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_UPD))
    else $error("result raised outside the update step");

endmodule
